// ===== src/bsm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsm_pkg: shared types and constants
// Opcode characters, status codes, op decode and controller/datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NOT    = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BRIDGE = 8'h23;
  localparam logic [7:0] CH_DROP   = 8'h24;
  localparam logic [7:0] CH_MOD    = 8'h25;
  localparam logic [7:0] CH_INI    = 8'h26;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_OUTC   = 8'h2C;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_OUTI   = 8'h2E;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DUP    = 8'h3A;
  localparam logic [7:0] CH_LEFT   = 8'h3C;
  localparam logic [7:0] CH_RIGHT  = 8'h3E;
  localparam logic [7:0] CH_RAND   = 8'h3F;
  localparam logic [7:0] CH_END    = 8'h40;
  localparam logic [7:0] CH_SWAP   = 8'h5C;
  localparam logic [7:0] CH_UP     = 8'h5E;
  localparam logic [7:0] CH_HBR    = 8'h5F;
  localparam logic [7:0] CH_GT     = 8'h60;
  localparam logic [7:0] CH_GET    = 8'h67;
  localparam logic [7:0] CH_PUT    = 8'h70;
  localparam logic [7:0] CH_DOWN   = 8'h76;
  localparam logic [7:0] CH_VBR    = 8'h7C;
  localparam logic [7:0] CH_INC    = 8'h7E;

  // result status
  localparam logic [2:0] ST_CONT = 3'd0;
  localparam logic [2:0] ST_END  = 3'd1;
  localparam logic [2:0] ST_BAD  = 3'd2;
  localparam logic [2:0] ST_PUT  = 3'd3;
  localparam logic [2:0] ST_OVF  = 3'd4;

  // output kind
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_INT  = 2'd1;
  localparam logic [1:0] KIND_CHAR = 2'd2;

  // heading
  localparam logic [1:0] HD_RIGHT = 2'd0;
  localparam logic [1:0] HD_LEFT  = 2'd1;
  localparam logic [1:0] HD_UP    = 2'd2;
  localparam logic [1:0] HD_DOWN  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_LIMIT  = 2'd2;

  localparam logic [11:0] DIM_MAX     = 12'd2048;
  localparam logic [11:0] WIDTH_RST   = 12'd80;
  localparam logic [11:0] HEIGHT_RST  = 12'd25;
  localparam logic [10:0] LIMIT_RST   = 11'd1024;

  typedef enum logic [4:0] {
    OP_NOP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_NOT, OP_GT,
    OP_DIR, OP_RAND, OP_HBR, OP_VBR, OP_QUOTE, OP_QEND, OP_PUSHC,
    OP_DUP, OP_SWAP, OP_DROP, OP_OUTI, OP_OUTC, OP_BRIDGE, OP_GET,
    OP_PUT, OP_INI, OP_INC, OP_END, OP_DIGIT, OP_BAD
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] npop;
    logic [1:0] npush;
  } op_info_t;

  typedef enum logic [4:0] {
    CMD_NOP, CMD_ACCEPT, CMD_CLR_WR, CMD_LD_ADDR, CMD_LD_WR, CMD_QUIET,
    CMD_FETCH_ADDR, CMD_FETCH_CAP, CMD_DECODE, CMD_POP_RD, CMD_POP_CAP,
    CMD_EXEC, CMD_MUL0, CMD_MUL1, CMD_MUL2, CMD_MUL3, CMD_DIV_START,
    CMD_DIV_CAP, CMD_GP_ADDR, CMD_G_CAP, CMD_P_WR, CMD_PUSH, CMD_FINISH
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e    cmd;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic     clr_last;
    logic     func;
    logic     terminal;
    op_info_t info;
    logic     a_zero;
    logic     div_busy;
    logic     out_free;
  } dp_stat_t;

  function automatic op_info_t decode_op(logic [7:0] c, logic quote);
    op_info_t r;
    r.op    = OP_BAD;
    r.npop  = 2'd0;
    r.npush = 2'd0;
    if (quote) begin
      if (c == CH_QUOTE) begin
        r.op = OP_QEND;
      end else begin
        r.op = OP_PUSHC; r.npush = 2'd1;
      end
    end else begin
      case (c)
        CH_NUL, CH_SPACE: r.op = OP_NOP;
        CH_ADD:    begin r.op = OP_ADD;  r.npop = 2'd2; r.npush = 2'd1; end
        CH_SUB:    begin r.op = OP_SUB;  r.npop = 2'd2; r.npush = 2'd1; end
        CH_MUL:    begin r.op = OP_MUL;  r.npop = 2'd2; r.npush = 2'd1; end
        CH_DIV:    begin r.op = OP_DIV;  r.npop = 2'd2; r.npush = 2'd1; end
        CH_MOD:    begin r.op = OP_MOD;  r.npop = 2'd2; r.npush = 2'd1; end
        CH_NOT:    begin r.op = OP_NOT;  r.npop = 2'd1; r.npush = 2'd1; end
        CH_GT:     begin r.op = OP_GT;   r.npop = 2'd2; r.npush = 2'd1; end
        CH_RIGHT, CH_LEFT, CH_UP, CH_DOWN: r.op = OP_DIR;
        CH_RAND:   r.op = OP_RAND;
        CH_HBR:    begin r.op = OP_HBR;  r.npop = 2'd1; end
        CH_VBR:    begin r.op = OP_VBR;  r.npop = 2'd1; end
        CH_QUOTE:  r.op = OP_QUOTE;
        CH_DUP:    begin r.op = OP_DUP;  r.npop = 2'd1; r.npush = 2'd2; end
        CH_SWAP:   begin r.op = OP_SWAP; r.npop = 2'd2; r.npush = 2'd2; end
        CH_DROP:   begin r.op = OP_DROP; r.npop = 2'd1; end
        CH_OUTI:   begin r.op = OP_OUTI; r.npop = 2'd1; end
        CH_OUTC:   begin r.op = OP_OUTC; r.npop = 2'd1; end
        CH_BRIDGE: r.op = OP_BRIDGE;
        CH_GET:    begin r.op = OP_GET;  r.npop = 2'd2; r.npush = 2'd1; end
        CH_PUT:    begin r.op = OP_PUT;  r.npop = 2'd3; end
        CH_INI:    begin r.op = OP_INI;  r.npush = 2'd1; end
        CH_INC:    begin r.op = OP_INC;  r.npush = 2'd1; end
        CH_END:    r.op = OP_END;
        default: begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            r.op = OP_DIGIT; r.npush = 2'd1;
          end
        end
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/bsm_if.sv =====
// ----------------------------------------------------------------------------
// bsm_if: word channels
// Step/load words in, result words out; valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsm_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [10:0] cell_col;
  logic [10:0] cell_row;
  logic [7:0]  cell_code;
  logic signed [63:0] user_value;
  logic        user_eof;
  logic [1:0]  random_dir;

  modport source (output valid, func, cell_col, cell_row, cell_code, user_value,
                  user_eof, random_dir, input ready);
  modport sink   (input valid, func, cell_col, cell_row, cell_code, user_value,
                  user_eof, random_dir, output ready);
endinterface

interface bsm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  out_kind;
  logic signed [63:0] out_value;
  logic        input_used;

  modport source (output valid, status, out_kind, out_value, input_used,
                  input ready);
  modport sink   (input valid, status, out_kind, out_value, input_used,
                  output ready);
endinterface

`default_nettype wire

// ===== src/bsm_ram.sv =====
// ----------------------------------------------------------------------------
// bsm_ram: generic memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/bsm_div.sv =====
// ----------------------------------------------------------------------------
// bsm_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dvd_i,
  input  wire logic [63:0] dvs_i,
  output logic             busy_o,
  output logic [63:0]      quo_o,
  output logic [63:0]      rem_o
);

  logic [64:0] rem_q;
  logic [63:0] quo_q, dvs_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [64:0] shl, diff;

  assign shl  = {rem_q[63:0], quo_q[63]};
  assign diff = shl - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'd64;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dvd_i;
      dvs_q <= dvs_i;
    end else if (busy_q) begin
      if (!diff[64]) begin
        rem_q <= diff;
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= shl;
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[63:0];

endmodule

`default_nettype wire

// ===== src/bsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsm_ctrl: step sequencer
// Walks grid clear, load writes, fetch, pops, execute, multi-cycle units, pushes and result.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_ctrl
  import bsm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  typedef enum logic [25:0] {
    S_CLEAR = 26'd1 << 0,  S_IDLE  = 26'd1 << 1,  S_DISP  = 26'd1 << 2,
    S_LADDR = 26'd1 << 3,  S_LWR   = 26'd1 << 4,  S_QUIET = 26'd1 << 5,
    S_FADDR = 26'd1 << 6,  S_FRD   = 26'd1 << 7,  S_FCAP  = 26'd1 << 8,
    S_DEC   = 26'd1 << 9,  S_ROUTE = 26'd1 << 10, S_POP   = 26'd1 << 11,
    S_POPC  = 26'd1 << 12, S_EXEC  = 26'd1 << 13, S_MUL0  = 26'd1 << 14,
    S_MUL1  = 26'd1 << 15, S_MUL2  = 26'd1 << 16, S_MUL3  = 26'd1 << 17,
    S_DIVS  = 26'd1 << 18, S_DIVW  = 26'd1 << 19, S_GADR  = 26'd1 << 20,
    S_GRD   = 26'd1 << 21, S_GCAP  = 26'd1 << 22, S_PWR   = 26'd1 << 23,
    S_PUSH  = 26'd1 << 24, S_FIN   = 26'd1 << 25
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic [2:0] cnt_inc;

  assign cnt_inc    = {1'b0, cnt_q} + 3'd1;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o.cmd = CMD_NOP;
    cmd_o.idx = cnt_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.cmd = CMD_CLR_WR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cmd = CMD_ACCEPT;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        if (!stat_i.func) state_d = S_LADDR;
        else if (stat_i.terminal) state_d = S_QUIET;
        else state_d = S_FADDR;
      end
      S_LADDR: begin cmd_o.cmd = CMD_LD_ADDR; state_d = S_LWR; end
      S_LWR:   begin cmd_o.cmd = CMD_LD_WR;   state_d = S_QUIET; end
      S_QUIET: begin
        if (stat_i.out_free) begin
          cmd_o.cmd = CMD_QUIET;
          state_d   = S_IDLE;
        end
      end
      S_FADDR: begin cmd_o.cmd = CMD_FETCH_ADDR; state_d = S_FRD; end
      S_FRD:   state_d = S_FCAP;
      S_FCAP:  begin cmd_o.cmd = CMD_FETCH_CAP; state_d = S_DEC; end
      S_DEC:   begin cmd_o.cmd = CMD_DECODE; state_d = S_ROUTE; end
      S_ROUTE: begin
        cnt_d   = '0;
        state_d = (stat_i.info.npop != 2'd0) ? S_POP : S_EXEC;
      end
      S_POP:   begin cmd_o.cmd = CMD_POP_RD; state_d = S_POPC; end
      S_POPC: begin
        cmd_o.cmd = CMD_POP_CAP;
        if (cnt_inc < {1'b0, stat_i.info.npop}) begin
          cnt_d   = cnt_inc[1:0];
          state_d = S_POP;
        end else begin
          cnt_d   = '0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.cmd = CMD_EXEC;
        cnt_d     = '0;
        case (stat_i.info.op)
          OP_MUL:         state_d = S_MUL0;
          OP_DIV, OP_MOD: state_d = stat_i.a_zero ? S_PUSH : S_DIVS;
          OP_GET, OP_PUT: state_d = S_GADR;
          default:        state_d = (stat_i.info.npush != 2'd0) ? S_PUSH : S_FIN;
        endcase
      end
      S_MUL0: begin cmd_o.cmd = CMD_MUL0; state_d = S_MUL1; end
      S_MUL1: begin cmd_o.cmd = CMD_MUL1; state_d = S_MUL2; end
      S_MUL2: begin cmd_o.cmd = CMD_MUL2; state_d = S_MUL3; end
      S_MUL3: begin cmd_o.cmd = CMD_MUL3; state_d = S_PUSH; end
      S_DIVS: begin cmd_o.cmd = CMD_DIV_START; state_d = S_DIVW; end
      S_DIVW: begin
        if (!stat_i.div_busy) begin
          cmd_o.cmd = CMD_DIV_CAP;
          state_d   = S_PUSH;
        end
      end
      S_GADR: begin
        cmd_o.cmd = CMD_GP_ADDR;
        state_d   = (stat_i.info.op == OP_GET) ? S_GRD : S_PWR;
      end
      S_GRD:  state_d = S_GCAP;
      S_GCAP: begin cmd_o.cmd = CMD_G_CAP; state_d = S_PUSH; end
      S_PWR:  begin cmd_o.cmd = CMD_P_WR;  state_d = S_FIN; end
      S_PUSH: begin
        cmd_o.cmd = CMD_PUSH;
        if (cnt_inc < {1'b0, stat_i.info.npush}) begin
          cnt_d = cnt_inc[1:0];
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.cmd = CMD_FINISH;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/bsm_dp.sv =====
// ----------------------------------------------------------------------------
// bsm_dp: interpreter datapath
// Machine state, code grid, value stack, ALU, multiplier, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_dp
  import bsm_pkg::*;
#(
  parameter int GRID_CELLS  = 2048,
  parameter int STACK_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_stat_t         stat_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [11:0] cfg_data_i,
  bsm_in_if.sink           in_ch,
  bsm_out_if.source        out_ch
);

  localparam int GAW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int LW  = ((DW > 11) ? DW : 11) + 1;

  // latched input word
  logic        func_q, eof_q;
  logic [10:0] lcol_q, lrow_q;
  logic [7:0]  code_q;
  logic [63:0] user_q;
  logic [1:0]  rand_q;

  logic [11:0] width_q, height_q;
  logic [10:0] limit_q;
  logic [10:0] col_q, row_q;
  logic [1:0]  head_q;
  logic        quote_q;
  logic [2:0]  final_q;
  logic [DW-1:0]  depth_q;
  logic [GAW-1:0] clr_q;

  logic [7:0]  c_q;
  op_info_t    info_q;
  logic [23:0] gaddr_q;
  logic        ok_q, oog_q, empty_q;
  logic [63:0] a_q, b_q, v_q, res0_q, res1_q, mulp_q;
  logic [1:0]  kind_q;
  logic [63:0] outv_q;
  logic        used_q;
  logic [2:0]  st_q;

  logic        ov_q, oused_q;
  logic [2:0]  ost_q;
  logic [1:0]  okind_q;
  logic [63:0] oval_q;

  logic [11:0] w_eff, h_eff;
  logic [LW-1:0] lim_ext, lim_eff;
  logic [10:0] fcol, frow, mcol, mrow, acol, arow;
  logic [11:0] mw;
  logic [23:0] maddr;
  logic        g_oog;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [7:0]  grd;
  logic [63:0] srd, popv, pushv, div_q, div_r;
  logic        div_busy;
  logic [DW-1:0] depth_m1;
  logic        gwe, swe;
  logic [GAW-1:0] gwaddr;
  logic [7:0]  gwdata;
  logic [2:0]  fin_st;
  logic        out_free;

  // register clamps
  always_comb begin
    w_eff = (width_q == 12'd0) ? 12'd1 : ((width_q > DIM_MAX) ? DIM_MAX : width_q);
    h_eff = (height_q == 12'd0) ? 12'd1 : ((height_q > DIM_MAX) ? DIM_MAX : height_q);
    lim_ext = LW'(limit_q);
    if (lim_ext < LW'(2)) lim_eff = LW'(2);
    else if (lim_ext > LW'(STACK_DEPTH)) lim_eff = LW'(STACK_DEPTH);
    else lim_eff = lim_ext;
  end

  // pointer advance along heading
  always_comb begin
    acol = col_q;
    arow = row_q;
    case (head_q)
      HD_RIGHT: acol = ({1'b0, col_q} + 12'd1 >= w_eff) ? 11'd0 : col_q + 11'd1;
      HD_LEFT:  acol = (col_q == 11'd0) ? 11'(w_eff - 12'd1) : col_q - 11'd1;
      HD_UP:    arow = (row_q == 11'd0) ? 11'(h_eff - 12'd1) : row_q - 11'd1;
      HD_DOWN:  arow = ({1'b0, row_q} + 12'd1 >= h_eff) ? 11'd0 : row_q + 11'd1;
      default:  acol = col_q;
    endcase
  end

  // cell address: column + row * width
  assign fcol  = ({1'b0, col_q} >= w_eff) ? 11'd0 : col_q;
  assign frow  = ({1'b0, row_q} >= h_eff) ? 11'd0 : row_q;
  assign g_oog = b_q[63] | a_q[63] | (b_q >= 64'(w_eff)) | (a_q >= 64'(h_eff));
  always_comb begin
    case (cmd_i.cmd)
      CMD_FETCH_ADDR: begin mcol = fcol;       mrow = frow;       end
      CMD_GP_ADDR:    begin mcol = b_q[10:0];  mrow = a_q[10:0];  end
      default:        begin mcol = lcol_q;     mrow = lrow_q;     end
    endcase
    mw    = w_eff;
    maddr = 24'(mcol) + 24'(mrow) * 24'(mw);
  end

  // shared 32x32 multiplier
  always_comb begin
    case (cmd_i.cmd)
      CMD_MUL1: begin mul_a = a_q[31:0];  mul_b = b_q[63:32]; end
      CMD_MUL2: begin mul_a = a_q[63:32]; mul_b = b_q[31:0];  end
      default:  begin mul_a = a_q[31:0];  mul_b = b_q[31:0];  end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  // memories
  assign depth_m1 = depth_q - DW'(1);
  assign popv     = empty_q ? 64'd0 : srd;
  assign pushv    = (cmd_i.idx == 2'd0) ? res0_q : res1_q;
  assign swe      = (cmd_i.cmd == CMD_PUSH) && (depth_q < DW'(STACK_DEPTH));

  always_comb begin
    gwe    = 1'b0;
    gwaddr = gaddr_q[GAW-1:0];
    gwdata = code_q;
    case (cmd_i.cmd)
      CMD_CLR_WR: begin gwe = 1'b1; gwaddr = clr_q; gwdata = CH_SPACE; end
      CMD_LD_WR:  gwe = ok_q;
      CMD_P_WR:   begin gwe = ok_q; gwdata = v_q[7:0]; end
      default:    gwe = 1'b0;
    endcase
  end

  bsm_ram #(.WIDTH(8), .DEPTH(GRID_CELLS)) u_grid (
    .clk_i   (clk_i),
    .we_i    (gwe),
    .waddr_i (gwaddr),
    .wdata_i (gwdata),
    .raddr_i (gaddr_q[GAW-1:0]),
    .rdata_o (grd)
  );

  bsm_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (swe),
    .waddr_i (depth_q[SAW-1:0]),
    .wdata_i (pushv),
    .raddr_i (depth_m1[SAW-1:0]),
    .rdata_o (srd)
  );

  bsm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cmd == CMD_DIV_START),
    .dvd_i   (b_q[63] ? 64'd0 - b_q : b_q),
    .dvs_i   (a_q[63] ? 64'd0 - a_q : a_q),
    .busy_o  (div_busy),
    .quo_o   (div_q),
    .rem_o   (div_r)
  );

  assign fin_st = (st_q == ST_CONT && (LW'(depth_q) + LW'(1) >= lim_eff)) ? ST_OVF : st_q;
  assign out_free = !ov_q || out_ch.ready;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      limit_q  <= LIMIT_RST;
      col_q    <= '0;
      row_q    <= '0;
      head_q   <= HD_RIGHT;
      quote_q  <= 1'b0;
      final_q  <= ST_CONT;
      depth_q  <= '0;
      clr_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          CFG_LIMIT:  limit_q  <= cfg_data_i[10:0];
          default:    limit_q  <= limit_q;
        endcase
      end
      // load the result register on finish or quiet, drop it once taken
      if (cmd_i.cmd == CMD_FINISH || cmd_i.cmd == CMD_QUIET) ov_q <= 1'b1;
      else if (out_ch.ready) ov_q <= 1'b0;
      case (cmd_i.cmd)
        CMD_CLR_WR:     clr_q <= clr_q + GAW'(1);
        CMD_FETCH_ADDR: begin col_q <= fcol; row_q <= frow; end
        CMD_POP_RD:     if (depth_q != '0) depth_q <= depth_m1;
        CMD_PUSH:       if (swe) depth_q <= depth_q + DW'(1);
        CMD_EXEC: begin
          case (info_q.op)
            OP_DIR: begin
              case (c_q)
                CH_LEFT: head_q <= HD_LEFT;
                CH_UP:   head_q <= HD_UP;
                CH_DOWN: head_q <= HD_DOWN;
                default: head_q <= HD_RIGHT;
              endcase
            end
            OP_RAND:   head_q  <= rand_q;
            OP_HBR:    head_q  <= (a_q == 64'd0) ? HD_RIGHT : HD_LEFT;
            OP_VBR:    head_q  <= (a_q == 64'd0) ? HD_DOWN : HD_UP;
            OP_QUOTE:  quote_q <= 1'b1;
            OP_QEND:   quote_q <= 1'b0;
            OP_BRIDGE: begin col_q <= acol; row_q <= arow; end
            default:   quote_q <= quote_q;
          endcase
        end
        CMD_FINISH: begin
          final_q <= fin_st;
          if (fin_st == ST_CONT) begin
            col_q <= acol;
            row_q <= arow;
          end
        end
        default:   clr_q <= clr_q;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.cmd)
      CMD_ACCEPT: begin
        func_q <= in_ch.func;
        lcol_q <= in_ch.cell_col;
        lrow_q <= in_ch.cell_row;
        code_q <= in_ch.cell_code;
        user_q <= in_ch.user_value;
        eof_q  <= in_ch.user_eof;
        rand_q <= in_ch.random_dir;
      end
      CMD_LD_ADDR: begin
        gaddr_q <= maddr;
        ok_q    <= ({1'b0, lcol_q} < w_eff) && ({1'b0, lrow_q} < h_eff) &&
                   (maddr < 24'(GRID_CELLS));
      end
      CMD_FETCH_ADDR: begin
        gaddr_q <= maddr;
        ok_q    <= maddr < 24'(GRID_CELLS);
        kind_q  <= KIND_NONE;
        outv_q  <= '0;
        used_q  <= 1'b0;
        st_q    <= ST_CONT;
      end
      CMD_FETCH_CAP: c_q <= ok_q ? grd : CH_SPACE;
      CMD_DECODE:    info_q <= decode_op(c_q, quote_q);
      CMD_POP_RD:    empty_q <= (depth_q == '0);
      CMD_POP_CAP: begin
        case (cmd_i.idx)
          2'd0:    a_q <= popv;
          2'd1:    b_q <= popv;
          default: v_q <= popv;
        endcase
      end
      CMD_EXEC: begin
        res1_q <= (info_q.op == OP_SWAP) ? b_q : a_q;
        case (info_q.op)
          OP_ADD:   res0_q <= a_q + b_q;
          OP_SUB:   res0_q <= b_q - a_q;
          OP_NOT:   res0_q <= {63'd0, a_q == 64'd0};
          OP_GT:    res0_q <= {63'd0, $signed(b_q) > $signed(a_q)};
          OP_PUSHC: res0_q <= {56'd0, c_q};
          OP_DIGIT: res0_q <= {56'd0, c_q - CH_ZERO};
          OP_DUP:   res0_q <= a_q;
          OP_SWAP:  res0_q <= a_q;
          OP_DIV: begin
            res0_q <= eof_q ? 64'd0 : user_q;
            used_q <= (a_q == 64'd0) && !eof_q;
          end
          OP_MOD:   res0_q <= 64'd0;
          OP_OUTI:  begin kind_q <= KIND_INT; outv_q <= a_q; end
          OP_OUTC:  begin kind_q <= KIND_CHAR; outv_q <= {56'd0, a_q[7:0]}; end
          OP_INI:   begin res0_q <= eof_q ? 64'd0 : user_q; used_q <= !eof_q; end
          OP_INC: begin
            res0_q <= eof_q ? 64'd0 : {56'd0, user_q[7:0]};
            used_q <= !eof_q;
          end
          OP_END:   st_q <= ST_END;
          OP_BAD:   st_q <= ST_BAD;
          default:  res0_q <= a_q;
        endcase
      end
      CMD_MUL0: mulp_q <= mul_p;
      CMD_MUL1: begin res0_q <= mulp_q; mulp_q <= mul_p; end
      CMD_MUL2: begin
        res0_q[63:32] <= res0_q[63:32] + mulp_q[31:0];
        mulp_q        <= mul_p;
      end
      CMD_MUL3: res0_q[63:32] <= res0_q[63:32] + mulp_q[31:0];
      CMD_DIV_CAP: begin
        if (info_q.op == OP_DIV) begin
          res0_q <= (a_q[63] ^ b_q[63]) ? 64'd0 - div_q : div_q;
        end else begin
          res0_q <= b_q[63] ? 64'd0 - div_r : div_r;
        end
      end
      CMD_GP_ADDR: begin
        gaddr_q <= maddr;
        oog_q   <= g_oog;
        ok_q    <= !g_oog && (maddr < 24'(GRID_CELLS));
      end
      CMD_G_CAP: res0_q <= oog_q ? 64'd0 : {56'd0, ok_q ? grd : CH_SPACE};
      CMD_P_WR:  if (oog_q) st_q <= ST_PUT;
      CMD_FINISH: begin
        ost_q   <= fin_st;
        okind_q <= kind_q;
        oval_q  <= outv_q;
        oused_q <= used_q;
      end
      CMD_QUIET: begin
        ost_q   <= final_q;
        okind_q <= KIND_NONE;
        oval_q  <= '0;
        oused_q <= 1'b0;
      end
      default: c_q <= c_q;
    endcase
  end

  assign stat_o.clr_last = (clr_q == GAW'(GRID_CELLS - 1));
  assign stat_o.func     = func_q;
  assign stat_o.terminal = (final_q != ST_CONT);
  assign stat_o.info     = info_q;
  assign stat_o.a_zero   = (a_q == 64'd0);
  assign stat_o.div_busy = div_busy;
  assign stat_o.out_free = out_free;

  assign out_ch.valid      = ov_q;
  assign out_ch.status     = ost_q;
  assign out_ch.out_kind   = okind_q;
  assign out_ch.out_value  = oval_q;
  assign out_ch.input_used = oused_q;

endmodule

`default_nettype wire

// ===== src/befunge_stack_machine_step.sv =====
// ----------------------------------------------------------------------------
// befunge_stack_machine_step: Befunge-93 interpreter core
// Loads code grid cells and executes one instruction per step word.
// ----------------------------------------------------------------------------
//
//  channel  | dir | carries
//  ---------+-----+-----------------------------------------------------------
//  in_ch    | in  | func, cell_col/row/code, user_value, user_eof, random_dir
//  out_ch   | out | status, out_kind, out_value, input_used (one per word)
//  cfg_*    | in  | grid_width (0), grid_height (1), stack_limit (2)
//
// Load words, and steps after a terminal status, skip the fetch. Multiply, get,
// put and a nonzero divide/modulo pass through extra states; the divider makes
// one quotient bit a cycle. Pops and pushes are serialized on the single-read,
// single-write stack memory.
// After reset the grid store is swept to spaces, one cell a cycle, over all
// GRID_CELLS cells; no word is taken during that sweep.
// A finished result sits in an output register, so the next word is accepted
// while it waits; a stalled result holds the sequencer only at its end.
//
`default_nettype none

module befunge_stack_machine_step
  import bsm_pkg::*;
#(
  parameter int GRID_CELLS  = 2048,
  parameter int STACK_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  bsm_in_if.sink           in_ch,
  bsm_out_if.source        out_ch,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [11:0] cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: decides which datapath command runs each cycle
  bsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: machine state, grid and stack memories, arithmetic units
  bsm_dp #(
    .GRID_CELLS  (GRID_CELLS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ===== src/bsm_chk.sv =====
// ----------------------------------------------------------------------------
// bsm_chk: port checker
// Watches the result channel for handshake and status consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_chk
  import bsm_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [1:0]  out_kind,
  input wire logic [63:0] out_value,
  input wire logic        out_used
);

  logic term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= 1'b0;
    end else if (out_valid && out_ready && out_status != ST_CONT) begin
      term_q <= 1'b1;
    end
  end

  // hold a stalled word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result word dropped or changed while stalled");

  // terminal status sticks until reset
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && term_q |-> out_status != ST_CONT)
    else $error("run resumed after terminal status");

  // ended, unknown op and bad put print nothing and read nothing
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_status == ST_END || out_status == ST_BAD ||
                  out_status == ST_PUT) |-> out_kind == KIND_NONE && !out_used)
    else $error("terminal word carries output or input use");

  // character output lives in the low byte; output and input never together
  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind != KIND_NONE |->
      !out_used && (out_kind != KIND_CHAR || out_value[63:8] == 56'd0))
    else $error("malformed output word");

endmodule

bind befunge_stack_machine_step bsm_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_kind   (out_ch.out_kind),
  .out_value  (out_ch.out_value),
  .out_used   (out_ch.input_used)
);

`default_nettype wire
